// ===== sv/prefix_varint_delta_decoder_macros.svh =====
// assertion macros for the prefix varint delta decoder checker
// expects signals named clk and rst_n in the scope where a macro is used
`ifndef PREFIX_VARINT_DELTA_DECODER_MACROS_SVH
`define PREFIX_VARINT_DELTA_DECODER_MACROS_SVH

// same-cycle implication, off while in reset
`define PVDD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, off while in reset
`define PVDD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

// same-cycle implication that also holds during reset
`define PVDD_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("%m: check failed");

`endif

// ===== sv/pvdd_pkg.sv =====
// shared types and constants of the prefix varint delta decoder
// no dependencies; used by the channel interfaces, the top level and the checker
package pvdd_pkg;

    localparam int BYTE_W    = 8;
    localparam int VALUE_W   = 32;
    localparam int INDEX_W   = 16;
    localparam int MAX_W     = 16;
    localparam int REG_IDX_W = 1;
    localparam int PART_W    = 24;
    localparam int REM_W     = 3;

    // item commands
    typedef enum logic
    {
        CMD_START = 1'b0,
        CMD_BYTE  = 1'b1
    } command_t;

    // register indexes on the configuration port
    localparam logic [REG_IDX_W-1:0] REG_BASE_VALUE  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_ENTRIES = 1'b1;

    // lead byte tag masks and payload masks
    localparam logic [BYTE_W-1:0] TAG_1 = 8'h80;
    localparam logic [BYTE_W-1:0] TAG_2 = 8'hC0;
    localparam logic [BYTE_W-1:0] TAG_3 = 8'hE0;
    localparam logic [BYTE_W-1:0] TAG_4 = 8'hF0;
    localparam logic [BYTE_W-1:0] PAY_2 = 8'h3F;
    localparam logic [BYTE_W-1:0] PAY_3 = 8'h1F;
    localparam logic [BYTE_W-1:0] PAY_4 = 8'h0F;

endpackage

// ===== sv/pvdd_in_if.sv =====
// input byte channel of the prefix varint delta decoder
// depends on pvdd_pkg
interface pvdd_in_if;
    import pvdd_pkg::*;

    logic              valid;
    logic              ready;
    command_t          command;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, command, data_byte, last_byte, input ready);
    modport sink   (input valid, command, data_byte, last_byte, output ready);
endinterface

// ===== sv/pvdd_out_if.sv =====
// entry output channel of the prefix varint delta decoder
// depends on pvdd_pkg
interface pvdd_out_if;
    import pvdd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] entry_value;
    logic [INDEX_W-1:0]        entry_index;
    logic                      final_entry;

    modport source (output valid, entry_value, entry_index, final_entry, input ready);
    modport sink   (input valid, entry_value, entry_index, final_entry, output ready);
endinterface

// ===== sv/pvdd_cfg_if.sv =====
// configuration write channel of the prefix varint delta decoder
// depends on pvdd_pkg
interface pvdd_cfg_if;
    import pvdd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] index;
    logic [VALUE_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/prefix_varint_delta_decoder.sv =====
// top level of the prefix varint delta decoder
// depends on pvdd_pkg, pvdd_in_if, pvdd_out_if and pvdd_cfg_if
//
// Usage:
// item_ch carries one word per item: a start command, or one byte of the
// delta stream with a flag on the final byte. A start emits base_value as
// entry 0; every completed code adds its delta (1 to 5 bytes) to the running
// sum, and the new sum goes out on entry_ch with its index and a final flag.
// The list ends after max_entries entries, or at the final byte; a code cut
// short by the final byte adds zero. Bytes that arrive with no list open are
// dropped without a result.
// cfg_ch writes base_value (index 0) and max_entries (index 1); it is always ready. The user
// writes it only while no item is in flight; the block itself does not enforce this.
// Timing: an item is registered in the input register at acceptance, decoded from there,
// and its entry is registered in the result register that drives entry_ch. One item is accepted
// per cycle while entry_ch does not stall, set by the single byte decode and 32-bit add between the input
// register and the result register.
// Reset clears the list state, base_value and both valid flags, and sets max_entries to all ones.
// When entry_ch stalls, the result register holds, the input register holds
// its item and item_ch ready drops only once both are occupied.
module prefix_varint_delta_decoder #(
    parameter int COUNT_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    pvdd_in_if.sink    item_ch,
    pvdd_out_if.source entry_ch,
    pvdd_cfg_if.sink   cfg_ch
);
    import pvdd_pkg::*;

    localparam int CMP_W = (COUNT_BITS > MAX_W) ? COUNT_BITS : MAX_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // configuration registers
    logic [VALUE_W-1:0] base_value_reg;
    logic [MAX_W-1:0]   max_entries_reg;

    // input register
    logic              s1_valid_reg;
    command_t          s1_cmd_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_last_reg;

    // decoder state
    logic [VALUE_W-1:0]    sum_reg, sum_next;
    logic [PART_W-1:0]     partial_reg, partial_next;
    logic [REM_W-1:0]      remaining_reg, remaining_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  active_reg, active_next;

    // result register
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic               out_final_reg;

    // decode results
    logic                  emit;
    logic                  force_final;
    logic                  is_final;
    logic [COUNT_BITS-1:0] count_base;
    logic [COUNT_BITS-1:0] count_inc;
    logic [CMP_W-1:0]      count_inc_ext;
    logic [CMP_W-1:0]      count_base_ext;
    logic [CMP_W-1:0]      max_ext;
    logic [VALUE_W-1:0]    shifted;
    logic [REM_W-1:0]      remaining_dec;
    logic                  s1_take;

    // handshake: input register advances when the result register frees up
    assign s1_take       = s1_valid_reg && (!out_valid_reg || entry_ch.ready);
    assign item_ch.ready = !s1_valid_reg || s1_take;
    assign cfg_ch.ready  = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_value_reg  <= '0;
            max_entries_reg <= '1;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_BASE_VALUE:  base_value_reg  <= cfg_ch.data;
                REG_MAX_ENTRIES: max_entries_reg <= cfg_ch.data[MAX_W-1:0];
                default:         ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_ch.ready)
        begin
            s1_valid_reg <= item_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ch.ready && item_ch.valid)
        begin
            s1_cmd_reg  <= item_ch.command;
            s1_byte_reg <= item_ch.data_byte;
            s1_last_reg <= item_ch.last_byte;
        end
    end

    // byte decode and accumulate
    always_comb
    begin
        sum_next       = sum_reg;
        partial_next   = partial_reg;
        remaining_next = remaining_reg;
        active_next    = active_reg;
        count_base     = count_reg;
        emit           = 1'b0;
        force_final    = 1'b0;
        shifted        = {partial_reg, s1_byte_reg};
        remaining_dec  = remaining_reg - 1'b1;

        case (s1_cmd_reg)
            CMD_START:
            begin
                sum_next       = base_value_reg;
                partial_next   = '0;
                remaining_next = '0;
                count_base     = '0;
                active_next    = 1'b1;
                emit           = 1'b1;
            end
            CMD_BYTE:
            begin
                if (active_reg)
                begin
                    if (remaining_reg == '0)
                    begin
                        // lead byte picks the code length
                        if ((s1_byte_reg & TAG_1) == '0)
                        begin
                            sum_next    = sum_reg + VALUE_W'(s1_byte_reg);
                            emit        = 1'b1;
                            force_final = s1_last_reg;
                        end
                        else
                        begin
                            if ((s1_byte_reg & TAG_2) == TAG_1)
                            begin
                                partial_next   = PART_W'(s1_byte_reg & PAY_2);
                                remaining_next = REM_W'(1);
                            end
                            else if ((s1_byte_reg & TAG_3) == TAG_2)
                            begin
                                partial_next   = PART_W'(s1_byte_reg & PAY_3);
                                remaining_next = REM_W'(2);
                            end
                            else if ((s1_byte_reg & TAG_4) == TAG_3)
                            begin
                                partial_next   = PART_W'(s1_byte_reg & PAY_4);
                                remaining_next = REM_W'(3);
                            end
                            else
                            begin
                                partial_next   = '0;
                                remaining_next = REM_W'(4);
                            end
                            // cut short at the final byte: adds zero
                            emit        = s1_last_reg;
                            force_final = s1_last_reg;
                        end
                    end
                    else
                    begin
                        // continuation byte shifts in
                        partial_next   = shifted[PART_W-1:0];
                        remaining_next = remaining_dec;
                        if (remaining_dec == '0)
                        begin
                            sum_next     = sum_reg + shifted;
                            partial_next = '0;
                            emit         = 1'b1;
                            force_final  = s1_last_reg;
                        end
                        else
                        begin
                            emit        = s1_last_reg;
                            force_final = s1_last_reg;
                        end
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        // entry count and end of list
        count_inc      = (count_base == COUNT_MAX) ? count_base : count_base + 1'b1;
        count_inc_ext  = CMP_W'(count_inc);
        count_base_ext = CMP_W'(count_base);
        max_ext        = CMP_W'(max_entries_reg);
        is_final       = force_final || (count_inc_ext >= max_ext) || (count_inc == COUNT_MAX);
        count_next     = count_reg;
        if (emit)
        begin
            count_next = count_inc;
            if (is_final)
            begin
                active_next    = 1'b0;
                remaining_next = '0;
                partial_next   = '0;
            end
        end
        else if (s1_cmd_reg == CMD_START)
        begin
            count_next = count_base;
        end
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            partial_reg   <= '0;
            remaining_reg <= '0;
            count_reg     <= '0;
            active_reg    <= 1'b0;
        end
        else if (s1_take)
        begin
            sum_reg       <= sum_next;
            partial_reg   <= partial_next;
            remaining_reg <= remaining_next;
            count_reg     <= count_next;
            active_reg    <= active_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || entry_ch.ready)
        begin
            out_valid_reg <= s1_valid_reg && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take && emit)
        begin
            out_value_reg <= sum_next;
            out_index_reg <= count_base_ext[INDEX_W-1:0];
            out_final_reg <= is_final;
        end
    end

    assign entry_ch.valid       = out_valid_reg;
    assign entry_ch.entry_value = $signed(out_value_reg);
    assign entry_ch.entry_index = out_index_reg;
    assign entry_ch.final_entry = out_final_reg;

endmodule

// ===== sv/pvdd_checker.sv =====
// port-level checker for the prefix varint delta decoder, bound to the top level
// depends on pvdd_pkg and prefix_varint_delta_decoder_macros.svh
`include "prefix_varint_delta_decoder_macros.svh"

module pvdd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       in_command,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [pvdd_pkg::VALUE_W-1:0] out_value,
    input logic [pvdd_pkg::INDEX_W-1:0] out_index,
    input logic                       out_final
);
    import pvdd_pkg::*;

    // stalled entry keeps its valid
    `PVDD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // stalled entry keeps its payload
    `PVDD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
        $stable(out_value) && $stable(out_index) && $stable(out_final))

    // no entry shown while in reset
    `PVDD_ASSERT_ALWAYS(a_reset_idle, !rst_n, !out_valid)

    // a start reaches the output as entry 0 once it has passed the input register and the result register is free
    `PVDD_ASSERT_NEXT(a_start_entry,
        (in_valid && in_ready && (in_command == CMD_START)) ##1 (!out_valid || out_ready),
        out_valid && (out_index == '0))

endmodule

bind prefix_varint_delta_decoder pvdd_checker u_pvdd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (item_ch.valid),
    .in_ready   (item_ch.ready),
    .in_command (item_ch.command),
    .out_valid  (entry_ch.valid),
    .out_ready  (entry_ch.ready),
    .out_value  (entry_ch.entry_value),
    .out_index  (entry_ch.entry_index),
    .out_final  (entry_ch.final_entry)
);

// ===== bench/delta_list_checker.sv =====
// checker for the prefix varint delta decoder: watches the item, entry and config channels,
// rebuilds the decoded list on its own and compares every entry word
// depends on pvdd_pkg, pvdd_in_if, pvdd_out_if and pvdd_cfg_if
module delta_list_checker #(
    parameter int COUNT_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    pvdd_in_if   item_mon,
    pvdd_out_if  entry_mon,
    pvdd_cfg_if  cfg_mon,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pvdd_pkg::*;

    typedef struct packed
    {
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
        logic               last_flag;
    } list_entry_t;

    localparam longint unsigned COUNT_FULL = (64'd1 << COUNT_BITS) - 64'd1;

    list_entry_t entries_due[$];
    int          mismatch_count = 0;

    // configuration copy
    logic [VALUE_W-1:0] base_reg = '0;
    logic [MAX_W-1:0]   max_reg  = '1;

    // decoder state
    logic [VALUE_W-1:0]    sum        = '0;
    logic [VALUE_W-1:0]    delta_acc  = '0;
    logic [REM_W-1:0]      bytes_owed = '0;
    logic [COUNT_BITS-1:0] emitted    = '0;
    logic                  list_open  = 1'b0;

    assign errors = mismatch_count;

    // one line per mismatch
    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        $display("%0t ns: entry mismatch, %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // queue the running sum as the next entry of the list
    task automatic push_entry(input logic force_last);
        list_entry_t      e;
        longint unsigned  n;
        e.value = sum;
        e.index = INDEX_W'(emitted);
        n = 64'(emitted);
        if (n < COUNT_FULL)
        begin
            emitted = emitted + 1'b1;
            n = n + 1;
        end
        e.last_flag = force_last || n >= 64'(max_reg) || n >= COUNT_FULL;
        entries_due.push_back(e);
        if (e.last_flag)
        begin
            list_open  = 1'b0;
            bytes_owed = '0;
            delta_acc  = '0;
        end
    endtask

    // advance the decoder by one accepted item word
    task automatic decode_word(input command_t cmd, input logic [BYTE_W-1:0] b,
                               input logic last);
        if (cmd == CMD_START)
        begin
            sum        = base_reg;
            delta_acc  = '0;
            bytes_owed = '0;
            emitted    = '0;
            list_open  = 1'b1;
            push_entry(1'b0);
        end
        else if (list_open)
        begin
            if (bytes_owed == 0)
            begin
                if ((b & TAG_1) == 0)
                begin
                    sum = sum + b[6:0];
                    push_entry(last);
                end
                else
                begin
                    // lead byte of a longer code
                    if ((b & TAG_2) == TAG_1)
                    begin
                        delta_acc  = VALUE_W'(b & PAY_2);
                        bytes_owed = REM_W'(1);
                    end
                    else if ((b & TAG_3) == TAG_2)
                    begin
                        delta_acc  = VALUE_W'(b & PAY_3);
                        bytes_owed = REM_W'(2);
                    end
                    else if ((b & TAG_4) == TAG_3)
                    begin
                        delta_acc  = VALUE_W'(b & PAY_4);
                        bytes_owed = REM_W'(3);
                    end
                    else
                    begin
                        delta_acc  = '0;
                        bytes_owed = REM_W'(4);
                    end
                    if (last)
                        push_entry(1'b1);
                end
            end
            else
            begin
                // continuation byte
                delta_acc  = {delta_acc[VALUE_W-BYTE_W-1:0], b};
                bytes_owed = bytes_owed - 1'b1;
                if (bytes_owed == 0)
                begin
                    sum       = sum + delta_acc;
                    delta_acc = '0;
                    push_entry(last);
                end
                else if (last)
                begin
                    push_entry(1'b1);
                end
            end
        end
    endtask

    // compare one entry word with the oldest one due
    task automatic check_entry();
        list_entry_t want;
        if (entries_due.size() == 0)
        begin
            report_mismatch("entry with nothing due", entry_mon.entry_value, '0);
        end
        else
        begin
            want = entries_due.pop_front();
            if (entry_mon.entry_value !== want.value)
                report_mismatch("entry_value", entry_mon.entry_value, want.value);
            if (entry_mon.entry_index !== want.index)
                report_mismatch("entry_index", 32'(entry_mon.entry_index), 32'(want.index));
            if (entry_mon.final_entry !== want.last_flag)
                report_mismatch("final_entry", 32'(entry_mon.final_entry), 32'(want.last_flag));
        end
    endtask

    // sample all three channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   = '0;
            max_reg    = '1;
            sum        = '0;
            delta_acc  = '0;
            bytes_owed = '0;
            emitted    = '0;
            list_open  = 1'b0;
            entries_due.delete();
        end
        else
        begin
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                if (cfg_mon.index == REG_BASE_VALUE)
                    base_reg = cfg_mon.data;
                else if (cfg_mon.index == REG_MAX_ENTRIES)
                    max_reg = cfg_mon.data[MAX_W-1:0];
            end
            if (item_mon.valid && item_mon.ready)
                decode_word(item_mon.command, item_mon.data_byte, item_mon.last_byte);
            if (entry_mon.valid && entry_mon.ready)
                check_entry();
        end
        pending = entries_due.size();
    end

endmodule

// ===== bench/tb_prefix_varint_delta_decoder.sv =====
// testbench top for the prefix varint delta decoder: clock, reset, stimulus and verdict
// depends on pvdd_pkg, the channel interfaces, the decoder and delta_list_checker
module tb_prefix_varint_delta_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import pvdd_pkg::*;

    localparam int CYCLE_LIMIT  = 50000;
    localparam int PHASE_WORDS  = 270;
    localparam int HOLD_CYCLES  = 60;

    logic clk = 1'b0;
    logic rst_n;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_requests = 0;
    int   holds_done    = 0;
    logic hold_active   = 1'b0;
    int   words_sent    = 0;
    int   cycle_count   = 0;
    int   errors;
    int   pending;
    int   phase_goal;

    pvdd_in_if  item_ch();
    pvdd_out_if entry_ch();
    pvdd_cfg_if cfg_ch();

    prefix_varint_delta_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_ch  (item_ch),
        .entry_ch (entry_ch),
        .cfg_ch   (cfg_ch)
    );

    delta_list_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_mon  (item_ch),
        .entry_mon (entry_ch),
        .cfg_mon   (cfg_ch),
        .errors    (errors),
        .pending   (pending)
    );

    always #10 clk = ~clk;

    // entry receiver: random stalls, or held off while a long hold runs
    initial
    begin
        entry_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_active)
                entry_ch.ready = 1'b0;
            else
                entry_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long receiver hold-off, counted in cycles
    initial
    begin
        forever
        begin
            wait (hold_requests != holds_done);
            holds_done++;
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_active = 1'b0;
        end
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("prefix_varint_delta_decoder test failed");
        $finish;
    end

    // offer one item word and wait for its handshake
    task automatic send_word(input command_t cmd, input logic [BYTE_W-1:0] b,
                             input logic last);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        item_ch.command   = cmd;
        item_ch.data_byte = b;
        item_ch.last_byte = last;
        item_ch.valid     = 1'b1;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        @(negedge clk);
        item_ch.valid = 1'b0;
        words_sent++;
    endtask

    // one code of the given length with random payload, optionally cut short
    task automatic send_code(input int len, input logic mark_last, input logic cut);
        logic [BYTE_W-1:0] code_bytes [5];
        int                n_bytes;
        for (int j = 0; j < 5; j++)
            code_bytes[j] = BYTE_W'($urandom);
        case (len)
            1:       code_bytes[0] = code_bytes[0] & ~TAG_1;
            2:       code_bytes[0] = TAG_1 | (code_bytes[0] & PAY_2);
            3:       code_bytes[0] = TAG_2 | (code_bytes[0] & PAY_3);
            4:       code_bytes[0] = TAG_3 | (code_bytes[0] & PAY_4);
            default: code_bytes[0] = TAG_4 | (code_bytes[0] & PAY_4);
        endcase
        n_bytes = (cut && len > 1) ? $urandom_range(len - 1, 1) : len;
        for (int j = 0; j < n_bytes; j++)
            send_word(CMD_BYTE, code_bytes[j], mark_last && (j == n_bytes - 1));
    endtask

    // write one register through the config channel
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] value);
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        cfg_ch.valid = 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // wait for every due entry, then let silent items drain out of the pipeline
    task automatic settle();
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // a start, sometimes after a stray byte, followed by random codes, mostly closed by a final byte
    task automatic run_list();
        int  n_codes;
        logic ends_here;
        if ($urandom_range(5) == 0)
            send_word(CMD_BYTE, BYTE_W'($urandom), 1'($urandom));
        send_word(CMD_START, BYTE_W'($urandom), 1'($urandom));
        n_codes = $urandom_range(12, 1);
        for (int i = 0; i < n_codes; i++)
        begin
            ends_here = (i == n_codes - 1) && ($urandom_range(3) != 0);
            send_code($urandom_range(5, 1), ends_here, ends_here && ($urandom_range(4) == 0));
        end
    endtask

    // pick a register setting, extremes included
    task automatic random_setting();
        case ($urandom_range(5))
            0:       write_reg(REG_BASE_VALUE, 32'h8000_0000);
            1:       write_reg(REG_BASE_VALUE, 32'h7FFF_FFFF);
            2:       write_reg(REG_BASE_VALUE, 32'h0000_0000);
            default: write_reg(REG_BASE_VALUE, $urandom);
        endcase
        case ($urandom_range(5))
            0:       write_reg(REG_MAX_ENTRIES, 32'd1);
            1:       write_reg(REG_MAX_ENTRIES, 32'd2);
            2:       write_reg(REG_MAX_ENTRIES, 32'($urandom_range(8, 3)));
            3:       write_reg(REG_MAX_ENTRIES, 32'($urandom_range(40, 9)));
            default: write_reg(REG_MAX_ENTRIES, 32'hFFFF);
        endcase
    endtask

    initial
    begin
        item_ch.valid     = 1'b0;
        item_ch.command   = CMD_BYTE;
        item_ch.data_byte = '0;
        item_ch.last_byte = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_BASE_VALUE;
        cfg_ch.data       = '0;
        rst_n             = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: every code length at its largest value, 1- and 5-byte codes also at zero, wrap, restarts, cut codes
        write_reg(REG_BASE_VALUE, 32'h7FFF_FFFF);
        write_reg(REG_MAX_ENTRIES, 32'hFFFF);
        send_word(CMD_BYTE, 8'hAA, 1'b1);
        send_word(CMD_START, 8'hFF, 1'b1);
        send_word(CMD_BYTE, 8'h00, 1'b0);
        send_word(CMD_BYTE, 8'h7F, 1'b0);
        send_word(CMD_BYTE, 8'hBF, 1'b0);
        send_word(CMD_BYTE, 8'hFF, 1'b0);
        send_word(CMD_BYTE, 8'hDF, 1'b0);
        repeat (2) send_word(CMD_BYTE, 8'hFF, 1'b0);
        send_word(CMD_BYTE, 8'hEF, 1'b0);
        repeat (3) send_word(CMD_BYTE, 8'hFF, 1'b0);
        repeat (5) send_word(CMD_BYTE, 8'hFF, 1'b0);
        send_word(CMD_BYTE, 8'hF0, 1'b0);
        repeat (4) send_word(CMD_BYTE, 8'h00, 1'b0);
        send_word(CMD_BYTE, 8'h80, 1'b0);
        send_word(CMD_START, 8'h00, 1'b0);
        send_word(CMD_BYTE, 8'hC5, 1'b0);
        send_word(CMD_BYTE, 8'h12, 1'b1);
        send_word(CMD_BYTE, 8'h01, 1'b0);
        settle();
        // zero max acts as one
        write_reg(REG_BASE_VALUE, 32'h8000_0000);
        write_reg(REG_MAX_ENTRIES, 32'h0);
        send_word(CMD_START, 8'h00, 1'b0);
        send_word(CMD_BYTE, 8'h05, 1'b0);
        settle();
        write_reg(REG_MAX_ENTRIES, 32'd2);
        send_word(CMD_START, 8'h00, 1'b0);
        send_word(CMD_BYTE, 8'h01, 1'b0);
        send_word(CMD_BYTE, 8'h02, 1'b0);
        settle();

        // random phases with different idling on each side
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 28;
                    recv_idle_pct = 80;
                end
                1:
                begin
                    send_idle_pct = 80;
                    recv_idle_pct = 28;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_goal = words_sent + PHASE_WORDS;
            if (phase == 2)
            begin
                // receiver holds off while the sender keeps offering words
                write_reg(REG_MAX_ENTRIES, 32'hFFFF);
                hold_requests++;
                send_word(CMD_START, 8'h3C, 1'b0);
                for (int i = 0; i < 30; i++)
                    send_code(1, i == 29, 1'b0);
                settle();
            end
            while (words_sent < phase_goal)
            begin
                settle();
                random_setting();
                repeat ($urandom_range(5, 2)) run_list();
            end
            settle();
        end

        // drain and give the verdict
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("prefix_varint_delta_decoder test passed");
        else
            $display("prefix_varint_delta_decoder test failed");
        $finish;
    end
endmodule
